FILE: hw/rtl/ils_pkg.sv
// Package for the indexed list store: widths, action codes and the cell control struct.
package ils_pkg;

  // Fixed field widths and list depth
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ACT_W   = 2;

  // Request action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // Broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic               ins;    // committed insert this cycle
    logic               rem;    // committed removal this cycle
    logic [POS_W-1:0]   pos;    // request position
    logic [CNT_W-1:0]   count;  // entries held before the request
    logic [VALUE_W-1:0] data;   // value to insert
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/ils_if.sv
// Valid/ready channel interfaces for requests and responses of the list store.
interface ils_req_if;
  logic                        valid;
  logic                        ready;
  logic [ils_pkg::ACT_W-1:0]   action;
  logic [ils_pkg::POS_W-1:0]   position;
  logic [ils_pkg::VALUE_W-1:0] data_in;

  modport source (output valid, action, position, data_in, input ready);
  modport sink   (input valid, action, position, data_in, output ready);
endinterface

interface ils_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ils_pkg::VALUE_W-1:0] data_out;
  logic [ils_pkg::CNT_W-1:0]   entry_count;
  logic                        error;

  modport source (output valid, data_out, entry_count, error, input ready);
  modport sink   (input valid, data_out, entry_count, error, output ready);
endinterface

FILE: hw/rtl/ils_cell.sv
// One cell of the shifting list chain: holds one entry and moves it to a neighbour.
module ils_cell (
  input  logic                        clk_i,
  input  logic [ils_pkg::POS_W-1:0]   idx_i,
  input  ils_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ils_pkg::VALUE_W-1:0] left_i,
  input  logic [ils_pkg::VALUE_W-1:0] right_i,
  output logic [ils_pkg::VALUE_W-1:0] value_o,
  output logic [ils_pkg::VALUE_W-1:0] rd_o
);

  logic [ils_pkg::VALUE_W-1:0] value_d, value_q;
  logic                        at_pos, above_pos, in_fill, before_last;

  // Position of this cell relative to the request
  assign at_pos      = (idx_i == ctrl_i.pos);
  assign above_pos   = (idx_i > ctrl_i.pos);
  assign in_fill     = (idx_i <= ctrl_i.count);
  assign before_last = (({1'b0, idx_i} + (ils_pkg::POS_W+1)'(1)) <
                        {1'b0, ctrl_i.count});

  // Insert opens a gap at pos and shifts up; removal closes it and shifts down
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (at_pos) begin
        value_d = ctrl_i.data;
      end else if (above_pos && in_fill) begin
        value_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      if ((at_pos || above_pos) && before_last) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // Only the addressed cell drives the read bus
  assign rd_o    = at_pos ? value_q : '0;

endmodule

FILE: hw/rtl/indexed_list_store_core.sv
// Top level of the indexed list store: request decode, count, cell chain and response register.
// Response: the result of a request is registered and shown in the cycle after its transfer.
// Throughput: one request per cycle while the response side takes results;
//   the single response register limits this, all entries shift together.
// Reset: entry count and response valid clear; entries stay undefined until
//   written, no clearing pass is needed.
module indexed_list_store_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ils_req_if.sink   req_i,
  ils_rsp_if.source rsp_o
);

  localparam int unsigned D = ils_pkg::DEPTH;

  logic                        accept;
  logic                        err;
  logic                        is_ins, is_rem, is_rd;
  logic [ils_pkg::CNT_W-1:0]   count_d, count_q;
  logic [ils_pkg::VALUE_W-1:0] rd_data;
  ils_pkg::cell_ctrl_t         ctrl;

  logic [ils_pkg::VALUE_W-1:0] cell_val [D];
  logic [ils_pkg::VALUE_W-1:0] cell_rd  [D];

  logic                        rsp_valid_q;
  logic [ils_pkg::VALUE_W-1:0] data_q;
  logic [ils_pkg::CNT_W-1:0]   cnt_out_q;
  logic                        err_q;

  // Input transfer when the response register is free or being emptied
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Request decode and range checks
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    is_rd  = 1'b0;
    err    = 1'b1;
    unique case (req_i.action)
      ils_pkg::ACT_INSERT: begin
        is_ins = 1'b1;
        err    = (count_q == ils_pkg::DEPTH_CNT) || (req_i.position > count_q);
      end
      ils_pkg::ACT_REMOVE: begin
        is_rem = 1'b1;
        err    = (req_i.position >= count_q);
      end
      ils_pkg::ACT_READ: begin
        is_rd = 1'b1;
        err   = (req_i.position >= count_q);
      end
      default: err = 1'b1;
    endcase
  end

  // New count after a committed request
  always_comb begin
    count_d = count_q;
    if (accept && !err && is_ins) begin
      count_d = count_q + ils_pkg::CNT_W'(1);
    end else if (accept && !err && is_rem) begin
      count_d = count_q - ils_pkg::CNT_W'(1);
    end
  end

  // Broadcast to the chain
  assign ctrl.ins   = accept && !err && is_ins;
  assign ctrl.rem   = accept && !err && is_rem;
  assign ctrl.pos   = req_i.position;
  assign ctrl.count = count_q;
  assign ctrl.data  = req_i.data_in;

  // Chain of cells, each linked to its neighbours; the end cells see zero on the open side
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [ils_pkg::VALUE_W-1:0] left_v, right_v;
    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end
    if (i == D - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end

    ils_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (ils_pkg::POS_W'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_val[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // Read bus: OR of the one-hot cell outputs
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < D; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q    <= (!err && (is_rem || is_rd)) ? rd_data : '0;
      cnt_out_q <= count_d;
      err_q     <= err;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.data_out    = data_q;
  assign rsp_o.entry_count = cnt_out_q;
  assign rsp_o.error       = err_q;

endmodule

FILE: hw/rtl/ils_checker.sv
// Port-level checks for the indexed list store, bound to the top level.
module ils_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic [ils_pkg::ACT_W-1:0]   req_action_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [ils_pkg::VALUE_W-1:0] rsp_data_i,
  input logic [ils_pkg::CNT_W-1:0]   rsp_count_i,
  input logic                        rsp_error_i
);

  // Every request transfer yields a response in the next cycle
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> rsp_valid_i)
    else $error("no response after request transfer");

  // An unused action code is always refused
  a_bad_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && req_action_i != ils_pkg::ACT_INSERT &&
     req_action_i != ils_pkg::ACT_REMOVE && req_action_i != ils_pkg::ACT_READ)
    |=> (rsp_valid_i && rsp_error_i))
    else $error("unused action not flagged");

  // Refused requests return zero data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_error_i) |-> (rsp_data_i == '0))
    else $error("error response carries data");

  // Count never exceeds the list depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_count_i <= ils_pkg::DEPTH_CNT))
    else $error("entry count beyond depth");

  // No request is taken while a held response stalls
  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |-> !req_ready_i)
    else $error("request taken while response stalled");

endmodule

bind indexed_list_store_core ils_checker u_ils_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_action_i (req_i.action),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_data_i   (rsp_o.data_out),
  .rsp_count_i  (rsp_o.entry_count),
  .rsp_error_i  (rsp_o.error)
);
